[hw/rtl/lcat_pkg.sv]
// ----------------------------------------------------------------------------
// lcat_pkg
// Shared types, codes and defaults of the latency cause accumulator table.
// ----------------------------------------------------------------------------
package lcat_pkg;

  localparam int SLOTS_DEFAULT     = 128;
  localparam int KEY_DEPTH_DEFAULT = 12;
  localparam logic [30:0] LIMIT_RESET = 31'd5000;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [2:0] {
    OUT_READ  = 3'd0,
    OUT_FILT  = 3'd1,
    OUT_MATCH = 3'd2,
    OUT_INS   = 3'd3,
    OUT_FULL  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] total;
    logic [30:0] max;
  } stats_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [6:0]  entry_index;
    logic        entry_valid;
    stats_t      stats;
    logic [63:0] frame_out;
    logic        last;
  } res_t;

  function automatic res_t make_res(outcome_t oc, logic [6:0] idx, logic vld,
                                    stats_t st, logic [63:0] frame, logic lst);
    res_t r;
    r.outcome     = oc;
    r.entry_index = idx;
    r.entry_valid = vld;
    r.stats       = st;
    r.frame_out   = frame;
    r.last        = lst;
    return r;
  endfunction

endpackage

[hw/rtl/lcat_if.sv]
// ----------------------------------------------------------------------------
// lcat channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] frame_addr;
  logic        last_frame;
  logic signed [31:0] usecs;
  logic        interruptible;
  logic        user_task;
  logic [6:0]  read_index;

  modport source (output valid, cmd, frame_addr, last_frame, usecs, interruptible,
                  user_task, read_index, input ready);
  modport sink (input valid, cmd, frame_addr, last_frame, usecs, interruptible,
                user_task, read_index, output ready);
endinterface

interface lcat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [6:0]  entry_index;
  logic        entry_valid;
  logic [31:0] hit_count;
  logic [47:0] total_time;
  logic [30:0] max_time;
  logic [63:0] frame_out;
  logic        last;

  modport source (output valid, outcome, entry_index, entry_valid, hit_count,
                  total_time, max_time, frame_out, last, input ready);
  modport sink (input valid, outcome, entry_index, entry_valid, hit_count,
                total_time, max_time, frame_out, last, output ready);
endinterface

[hw/rtl/latency_cause_accumulator_table.sv]
// a plain frame or a clear is taken in IDLE, a filtered latency goes via S_FILT; a
// read of an empty slot or out-of-range index gives one result, else one per key
// word up to the first zero word; an applied latency scans slots in order, comparing
// key words of occupied ones, then updates on a hit, reports a full table or writes
// the key on an insert. one transaction at a time, ready is low until the sequencer
// is idle; a stalled result holds it. reset and clear empty the table; limit 5000.
// ----------------------------------------------------------------------------
// latency_cause_accumulator_table
// Accumulates latency statistics per backtrace key in a slot table.
// ----------------------------------------------------------------------------
module latency_cause_accumulator_table #(
  parameter int SLOTS     = lcat_pkg::SLOTS_DEFAULT,
  parameter int KEY_DEPTH = lcat_pkg::KEY_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  lcat_req_if.sink    req,
  lcat_rsp_if.source  rsp
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = $clog2(KEY_DEPTH + 1);
  localparam logic [QW-1:0] Q_LAST = QW'(KEY_DEPTH - 1);
  localparam logic [SW:0] EMPTY_NONE = (SW+1)'(SLOTS);
  localparam logic [SW:0] EMPTY_LIMIT = (SW+1)'(SLOTS - 1);

  typedef enum logic [3:0] {
    IDLE, S_FILT, S_CHK, S_WAIT, S_CMP, S_UPD, S_END, S_FULL, S_INS, S_INSF,
    R_FIRST, R_WAIT0, R_NXT, R_WAIT, R_LOOK, R_OOR
  } state_t;

  state_t state;
  logic [30:0] limit;
  logic [SLOTS-1:0] occ;
  logic [SLOTS-1:0] written;
  logic [63:0] pend [KEY_DEPTH];
  logic [LW-1:0] pend_len;
  logic [SW-1:0] slot;
  logic [QW-1:0] q;
  logic [SW:0] empty;
  logic [30:0] lat;
  logic [6:0] ridx;
  logic [63:0] cur;
  logic ov;
  lcat_pkg::res_t ores;

  logic [63:0] key_mem [SLOTS << QW];
  logic [63:0] rd_key;
  lcat_pkg::stats_t stats_mem [SLOTS];
  lcat_pkg::stats_t rd_stats;

  logic key_we;
  logic stats_we;
  lcat_pkg::stats_t stats_wd;
  lcat_pkg::stats_t stats_q;
  lcat_pkg::stats_t upd;
  logic [48:0] tsum;
  logic out_free;
  logic filt;
  logic emit;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{slot, q}] <= pend[q];
    end
    rd_key <= key_mem[{slot, q}];
  end

  always_ff @(posedge clk) begin
    if (stats_we) begin
      stats_mem[slot] <= stats_wd;
    end
    rd_stats <= stats_mem[slot];
  end

  // slots never written since reset or the last clear read back as zero
  assign stats_q = written[slot] ? rd_stats : '0;

  assign tsum = {1'b0, stats_q.total} + 49'(lat);
  always_comb begin
    upd = stats_q;
    if (stats_q.count != '1) begin
      upd.count = stats_q.count + 32'd1;
    end
    upd.total = tsum[48] ? '1 : tsum[47:0];
    if (lat > stats_q.max) begin
      upd.max = lat;
    end
  end

  assign out_free = !ov || rsp.ready;
  assign key_we = (state == S_INS);
  assign stats_we = ((state == S_UPD) || (state == S_INSF)) && out_free;
  assign stats_wd = (state == S_UPD) ? upd :
                    lcat_pkg::stats_t'{count: 32'd1, total: 48'(lat), max: lat};

  assign filt = (req.interruptible && (req.usecs > $signed({1'b0, limit})))
                || (req.usecs <= 32'sd0) || !req.user_task;

  assign req.ready = (state == IDLE);

  // a result is loaded into the output register this cycle
  always_comb begin
    case (state)
      S_FILT, S_UPD, S_INSF, R_OOR, R_LOOK: emit = out_free;
      S_FULL:  emit = out_free && (empty >= EMPTY_LIMIT);
      R_FIRST: emit = out_free && !occ[slot];
      R_NXT:   emit = out_free && (q == Q_LAST);
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      limit    <= lcat_pkg::LIMIT_RESET;
      occ      <= '0;
      written  <= '0;
      pend_len <= '0;
      ov       <= 1'b0;
      for (int i = 0; i < KEY_DEPTH; i++) begin
        pend[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      ov <= emit || (ov && !rsp.ready);
      case (state)
        IDLE: begin
          if (req.valid) begin
            case (req.cmd)
              lcat_pkg::CMD_FRAME: begin
                if (pend_len < LW'(KEY_DEPTH)) begin
                  pend[pend_len[QW-1:0]] <= req.frame_addr;
                  pend_len <= pend_len + LW'(1);
                end
                if (req.last_frame) begin
                  lat   <= req.usecs[30:0];
                  slot  <= '0;
                  q     <= '0;
                  empty <= EMPTY_NONE;
                  state <= filt ? S_FILT : S_CHK;
                end
              end
              lcat_pkg::CMD_CLEAR: begin
                occ     <= '0;
                written <= '0;
              end
              lcat_pkg::CMD_READ: begin
                ridx <= req.read_index;
                slot <= SW'(req.read_index);
                q    <= '0;
                if (32'(req.read_index) >= SLOTS) begin
                  state <= R_OOR;
                end else begin
                  state <= R_WAIT0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FILT: begin
          if (out_free) begin
            ores <= lcat_pkg::make_res(lcat_pkg::OUT_FILT, '0, 1'b0, '0, '0, 1'b1);
            state <= S_END;
          end
        end
        S_CHK: begin
          if (!occ[slot]) begin
            if (empty == EMPTY_NONE) begin
              empty <= {1'b0, slot};
            end
            if (slot == SW'(SLOTS - 1)) begin
              state <= S_FULL;
            end else begin
              slot <= slot + SW'(1);
            end
          end else begin
            q     <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_key != pend[q]) begin
            if (slot == SW'(SLOTS - 1)) begin
              state <= S_FULL;
            end else begin
              slot  <= slot + SW'(1);
              state <= S_CHK;
            end
          end else if ((pend[q] == '0) || (q == Q_LAST)) begin
            state <= S_UPD;
          end else begin
            q     <= q + QW'(1);
            state <= S_WAIT;
          end
        end
        S_UPD: begin
          if (out_free) begin
            ores <= lcat_pkg::make_res(lcat_pkg::OUT_MATCH, 7'(slot), 1'b1, upd,
                                       '0, 1'b1);
            state <= S_END;
          end
        end
        S_FULL: begin
          // scan done with no hit: insert or report a full table
          if (empty >= EMPTY_LIMIT) begin
            if (out_free) begin
              ores <= lcat_pkg::make_res(lcat_pkg::OUT_FULL, '0, 1'b0, '0, '0, 1'b1);
              state <= S_END;
            end
          end else begin
            slot  <= empty[SW-1:0];
            q     <= '0;
            state <= S_INS;
          end
        end
        S_INS: begin
          if (q == Q_LAST) begin
            state <= S_INSF;
          end else begin
            q <= q + QW'(1);
          end
        end
        S_INSF: begin
          if (out_free) begin
            occ[slot]     <= (pend[0] != '0);
            written[slot] <= 1'b1;
            ores <= lcat_pkg::make_res(lcat_pkg::OUT_INS, 7'(slot), pend[0] != '0,
                                       stats_wd, '0, 1'b1);
            state <= S_END;
          end
        end
        S_END: begin
          for (int i = 0; i < KEY_DEPTH; i++) begin
            pend[i] <= '0;
          end
          pend_len <= '0;
          state    <= IDLE;
        end
        R_OOR: begin
          if (out_free) begin
            ores <= lcat_pkg::make_res(lcat_pkg::OUT_READ, ridx, 1'b0, '0, '0, 1'b1);
            state <= IDLE;
          end
        end
        R_WAIT0: begin
          state <= R_FIRST;
        end
        R_FIRST: begin
          if (!occ[slot]) begin
            if (out_free) begin
              ores <= lcat_pkg::make_res(lcat_pkg::OUT_READ, ridx, 1'b0, stats_q,
                                         '0, 1'b1);
              state <= IDLE;
            end
          end else begin
            cur   <= rd_key;
            state <= R_NXT;
          end
        end
        R_NXT: begin
          // look one word ahead to know which result is the last one
          if (q == Q_LAST) begin
            if (out_free) begin
              ores <= lcat_pkg::make_res(lcat_pkg::OUT_READ, ridx, 1'b1, stats_q,
                                         cur, 1'b1);
              state <= IDLE;
            end
          end else begin
            q     <= q + QW'(1);
            state <= R_WAIT;
          end
        end
        R_WAIT: begin
          state <= R_LOOK;
        end
        R_LOOK: begin
          if (out_free) begin
            ores <= lcat_pkg::make_res(lcat_pkg::OUT_READ, ridx, 1'b1, stats_q,
                                       cur, rd_key == '0);
            cur  <= rd_key;
            state <= (rd_key == '0) ? IDLE : R_NXT;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = ov;
  assign rsp.outcome     = ores.outcome;
  assign rsp.entry_index = ores.entry_index;
  assign rsp.entry_valid = ores.entry_valid;
  assign rsp.hit_count   = ores.stats.count;
  assign rsp.total_time  = ores.stats.total;
  assign rsp.max_time    = ores.stats.max;
  assign rsp.frame_out   = ores.frame_out;
  assign rsp.last        = ores.last;

endmodule
